// ----- design/aids_pkg.sv -----
package aids_pkg;

	localparam int DEPTH_DEF = 32;

	localparam logic [2:0] ACT_CLEAR   = 3'd0;
	localparam logic [2:0] ACT_APPEND  = 3'd1;
	localparam logic [2:0] ACT_INSERT  = 3'd2;
	localparam logic [2:0] ACT_DELETE  = 3'd3;
	localparam logic [2:0] ACT_SEARCH  = 3'd4;
	localparam logic [2:0] ACT_DISPLAY = 3'd5;

	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_ELEM   = 2'd1;
	localparam logic [1:0] KIND_MATCH  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [31:0] value;
		logic [5:0]         position;
	} req_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] element;
		logic [5:0]         where;
		logic [1:0]         status;
		logic [5:0]         fill;
		logic               last;
	} res_t;

	typedef struct packed {
		logic load;
		logic sweep;
		logic report;
	} cmd_t;

	typedef struct packed {
		logic sweep_done;
		logic out_free;
	} sts_t;

endpackage

// ----- design/aids_ctrl.sv -----
module aids_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  aids_pkg::sts_t sts,
	output aids_pkg::cmd_t cmd
);
	import aids_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SWEEP,
		S_REPORT
	} state_t;

	state_t state_q;
	logic   stall_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stall_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_SWEEP;
						stall_q <= 1'b1;
					end
				end
				S_SWEEP: begin
					if (sts.sweep_done) begin
						state_q <= S_REPORT;
					end
				end
				S_REPORT: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
						stall_q <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
					stall_q <= 1'b0;
				end
			endcase
		end
	end

	assign req_stall  = stall_q;
	assign cmd.load   = (state_q == S_IDLE) && req_valid;
	assign cmd.sweep  = (state_q == S_SWEEP);
	assign cmd.report = (state_q == S_REPORT);

endmodule

// ----- design/aids_dp.sv -----
module aids_dp #(
	parameter int DEPTH = aids_pkg::DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  aids_pkg::cmd_t cmd,
	output aids_pkg::sts_t sts,
	input  aids_pkg::req_t req,
	output aids_pkg::res_t rsp,
	output logic           rsp_valid,
	input  logic           rsp_stall
);
	import aids_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = ((CW > 6) ? CW : 6) + 1;

	logic [31:0] mem [DEPTH];

	logic [CW-1:0] count_q;
	logic [CW-1:0] rem_q;
	logic [AW-1:0] ptr_q;
	logic [AW-1:0] idx_s1;
	logic          valid_s1;
	logic [31:0]   rdata_s1;
	logic [2:0]    action_q;
	logic [31:0]   value_q;
	logic [1:0]    status_q;
	logic [AW-1:0] wpos_q;
	res_t          rsp_q;
	logic          rsp_valid_q;

	logic [XW-1:0] pos_x, cnt_x;
	logic          full;
	logic [1:0]    ld_status;
	logic [CW-1:0] ld_rem;
	logic [AW-1:0] ld_ptr;
	logic [AW-1:0] ld_wpos;

	logic          shift, out_free, adv, hit, step, issue;
	logic          emit_item, emit_status;
	logic          we;
	logic [AW-1:0] wa;
	logic [31:0]   wd;
	logic [CW-1:0] next_cnt;
	res_t          item, stat;

	// operation setup and range checks
	assign pos_x = XW'(req.position);
	assign cnt_x = XW'(count_q);
	assign full  = (count_q == CW'(DEPTH));

	always_comb begin
		ld_status = ST_OK;
		ld_rem    = '0;
		ld_ptr    = '0;
		ld_wpos   = AW'(count_q);
		case (req.action)
			ACT_APPEND: begin
				if (full) ld_status = ST_FULL;
			end
			ACT_INSERT: begin
				if (full) begin
					ld_status = ST_FULL;
				end else if (pos_x == XW'(0) || pos_x > cnt_x + XW'(1)) begin
					ld_status = ST_RANGE;
				end else begin
					ld_rem  = CW'(cnt_x - pos_x + XW'(1));
					ld_ptr  = AW'(cnt_x - XW'(1));
					ld_wpos = AW'(pos_x - XW'(1));
				end
			end
			ACT_DELETE: begin
				if (pos_x == XW'(0) || pos_x > cnt_x) begin
					ld_status = ST_RANGE;
				end else begin
					ld_rem = CW'(cnt_x - pos_x);
					ld_ptr = AW'(pos_x);
				end
			end
			ACT_SEARCH, ACT_DISPLAY: begin
				ld_rem = count_q;
			end
			default: begin
				ld_status = ST_OK;
			end
		endcase
	end

	// sweep over the stored words
	assign shift       = (action_q == ACT_INSERT) || (action_q == ACT_DELETE);
	assign out_free    = !rsp_valid_q || !rsp_stall;
	assign adv         = shift || out_free;
	assign hit         = valid_s1 && ((action_q == ACT_DISPLAY) ||
	                     ((action_q == ACT_SEARCH) && (rdata_s1 == value_q)));
	assign step        = cmd.sweep && adv;
	assign issue       = step && (rem_q != '0);
	assign emit_item   = step && hit;
	assign emit_status = cmd.report && out_free;

	always_comb begin
		case (action_q)
			ACT_CLEAR: next_cnt = '0;
			ACT_APPEND, ACT_INSERT:
				next_cnt = (status_q == ST_OK) ? count_q + CW'(1) : count_q;
			ACT_DELETE:
				next_cnt = (status_q == ST_OK) ? count_q - CW'(1) : count_q;
			default: next_cnt = count_q;
		endcase
	end

	always_comb begin
		we = 1'b0;
		wa = wpos_q;
		wd = value_q;
		if (cmd.sweep && valid_s1 && shift) begin
			we = 1'b1;
			wa = (action_q == ACT_INSERT) ? idx_s1 + AW'(1) : idx_s1 - AW'(1);
			wd = rdata_s1;
		end else if (emit_status && status_q == ST_OK &&
		             (action_q == ACT_APPEND || action_q == ACT_INSERT)) begin
			we = 1'b1;
		end
	end

	always_comb begin
		item.kind    = (action_q == ACT_DISPLAY) ? KIND_ELEM : KIND_MATCH;
		item.element = (action_q == ACT_DISPLAY) ? rdata_s1 : '0;
		item.where   = 6'(CW'(idx_s1) + CW'(1));
		item.status  = ST_OK;
		item.fill    = 6'(count_q);
		item.last    = 1'b0;

		stat.kind    = KIND_STATUS;
		stat.element = '0;
		stat.where   = '0;
		stat.status  = status_q;
		stat.fill    = 6'(next_cnt);
		stat.last    = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (issue) rdata_s1 <= mem[ptr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= req.action;
			value_q  <= req.value;
			status_q <= ld_status;
			wpos_q   <= ld_wpos;
		end
		if (issue) idx_s1 <= ptr_q;
		if (emit_item) begin
			rsp_q <= item;
		end else if (emit_status) begin
			rsp_q <= stat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rem_q       <= '0;
			ptr_q       <= '0;
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				rem_q    <= ld_rem;
				ptr_q    <= ld_ptr;
				valid_s1 <= 1'b0;
			end else if (step) begin
				valid_s1 <= (rem_q != '0);
				if (rem_q != '0) begin
					rem_q <= rem_q - CW'(1);
					ptr_q <= (action_q == ACT_INSERT) ? ptr_q - AW'(1) : ptr_q + AW'(1);
				end
			end
			if (emit_status) count_q <= next_cnt;
			if (emit_item || emit_status) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign sts.sweep_done = (rem_q == '0) && !valid_s1;
	assign sts.out_free   = out_free;
	assign rsp            = rsp_q;
	assign rsp_valid      = rsp_valid_q;

endmodule

// ----- design/array_insert_delete_search_unit.sv -----
// Ordered array of up to DEPTH signed 32-bit entries with clear, append,
// insert, delete, search and display.
// req channel: one word per operation (action, value, position), taken when
// req_valid is high and req_stall is low. req_stall stays high from the
// accept until the operation's status word is loaded into the output register.
// rsp channel: display emits one word per entry, search one word per match,
// then every operation ends with one status word with last set.
// Sequence: after the accept, the entries are read one after another through
// the single memory read port, the read stage drains when any entry was read,
// the sweep ends and the status word is reported. The number of entries read
// is fill for search and display, fill-position+1 for insert and fill-position
// for delete, and none otherwise. The next req word can be taken only once
// the status word of the current operation is loaded.
// While rsp_stall holds a word in the output register the search or display
// sweep waits; insert and delete shifts run on and wait only at the status
// word.
// Reset empties the array (fill zero) and drops rsp_valid; no clearing pass.
module array_insert_delete_search_unit #(
	parameter int DEPTH = aids_pkg::DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  aids_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output aids_pkg::res_t rsp
);
	import aids_pkg::*;

	cmd_t cmd;
	sts_t sts;

	aids_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	aids_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall)
	);

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
	import aids_pkg::*;

	localparam logic [2:0] ACT_SPARE6 = 3'd6;
	localparam logic [2:0] ACT_SPARE7 = 3'd7;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;

	class array_mirror;
		logic signed [31:0] slots [DEPTH_DEF];
		int fill;
		res_t pending_words[$];
		int mismatches;

		function new();
			fill = 0;
			mismatches = 0;
		endfunction

		function void put(logic [1:0] k, logic signed [31:0] e, int w, logic [1:0] s, logic l);
			res_t r;
			r.kind = k;
			r.element = e;
			r.where = 6'(w);
			r.status = s;
			r.fill = 6'(fill);
			r.last = l;
			pending_words.push_back(r);
		endfunction

		// accepted operation word: update the array, queue its output words
		function void apply_op(req_t op);
			logic [1:0] st;
			int p;
			int i;
			st = ST_OK;
			p = op.position;
			case (op.action)
				ACT_CLEAR: fill = 0;
				ACT_APPEND: begin
					if (fill >= DEPTH_DEF) st = ST_FULL;
					else begin
						slots[fill] = op.value;
						fill++;
					end
				end
				ACT_INSERT: begin
					if (fill >= DEPTH_DEF) st = ST_FULL;
					else if (p < 1 || p > fill + 1) st = ST_RANGE;
					else begin
						for (i = fill; i >= p; i--) slots[i] = slots[i - 1];
						slots[p - 1] = op.value;
						fill++;
					end
				end
				ACT_DELETE: begin
					if (p < 1 || p > fill) st = ST_RANGE;
					else begin
						for (i = p - 1; i < fill - 1; i++) slots[i] = slots[i + 1];
						fill--;
					end
				end
				ACT_SEARCH: begin
					for (i = 0; i < fill; i++)
						if (slots[i] == op.value) put(KIND_MATCH, 0, i + 1, ST_OK, 1'b0);
				end
				ACT_DISPLAY: begin
					for (i = 0; i < fill; i++) put(KIND_ELEM, slots[i], i + 1, ST_OK, 1'b0);
				end
				default: ;
			endcase
			put(KIND_STATUS, 0, 0, st, 1'b1);
		endfunction

		function void compare_field(string name, logic signed [32:0] want_v,
			logic signed [32:0] got_v);
			if (got_v !== want_v) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
				mismatches++;
			end
		endfunction

		function void check_word(res_t got);
			res_t want;
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word, expected none, got %h", $time, got);
				mismatches++;
				return;
			end
			want = pending_words.pop_front();
			compare_field("kind", want.kind, got.kind);
			compare_field("element", want.element, got.element);
			compare_field("where", want.where, got.where);
			compare_field("status", want.status, got.status);
			compare_field("fill", want.fill, got.fill);
			compare_field("last", want.last, got.last);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	res_t rsp;

	array_mirror mirror;
	bit calm = 1'b0;
	bit hold_off = 1'b0;
	bit holding = 1'b0;
	int quiet_cycles = 0;

	array_insert_delete_search_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #6 clk = ~clk;

	function automatic req_t make_op(logic [2:0] act, logic signed [31:0] v, int p);
		req_t w;
		w.action = act;
		w.value = v;
		w.position = 6'(p);
		return w;
	endfunction

	// mostly a small pool so searches hit, sometimes any 32-bit value
	function automatic logic signed [31:0] pick_value();
		int v;
		if ($urandom_range(0, 9) < 7) begin
			v = $urandom_range(0, 3);
			return v - 1;
		end
		return $urandom;
	endfunction

	task automatic issue(input req_t w);
		if (!calm && !holding && $urandom_range(0, 2) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		mirror.apply_op(w);
	endtask

	task automatic random_op();
		logic [2:0] act;
		int pick;
		int p;
		int f;
		f = mirror.fill;
		pick = $urandom_range(0, 99);
		if (pick < 4) act = ACT_CLEAR;
		else if (pick < 34) act = ACT_APPEND;
		else if (pick < 56) act = ACT_INSERT;
		else if (pick < 74) act = ACT_DELETE;
		else if (pick < 86) act = ACT_SEARCH;
		else if (pick < 94) act = ACT_DISPLAY;
		else if (pick < 97) act = ACT_SPARE6;
		else act = ACT_SPARE7;
		if ($urandom_range(0, 4) == 0) p = $urandom_range(0, 63);
		else if (act == ACT_DELETE) p = (f == 0) ? 1 : $urandom_range(1, f);
		else p = $urandom_range(1, f + 1);
		issue(make_op(act, pick_value(), p));
	endtask

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		rsp_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off) begin
				hold_off = 1'b0;
				holding = 1'b1;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				holding = 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				rsp_stall <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) mirror.check_word(rsp);
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("** array_insert_delete_search_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		mirror = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// empty array and position checks
		issue(make_op(ACT_DISPLAY, 0, 0));
		issue(make_op(ACT_SEARCH, 0, 0));
		issue(make_op(ACT_DELETE, 0, 1));
		issue(make_op(ACT_DELETE, 0, 0));
		issue(make_op(ACT_INSERT, 3, 0));
		issue(make_op(ACT_INSERT, 3, 2));
		issue(make_op(ACT_INSERT, 32'sh80000000, 1));
		issue(make_op(ACT_APPEND, 32'sh7fffffff, 0));
		issue(make_op(ACT_APPEND, -1, 0));
		issue(make_op(ACT_INSERT, 0, 4));
		issue(make_op(ACT_INSERT, -1, 2));
		issue(make_op(ACT_SEARCH, -1, 0));
		issue(make_op(ACT_DISPLAY, 0, 0));
		issue(make_op(ACT_DELETE, 0, 6));
		issue(make_op(ACT_DELETE, 0, 63));
		issue(make_op(ACT_DELETE, 0, 5));
		issue(make_op(ACT_DELETE, 0, 1));
		issue(make_op(ACT_SPARE6, 5, 1));
		issue(make_op(ACT_SPARE7, -5, 2));
		issue(make_op(ACT_INSERT, 7, 1));
		issue(make_op(ACT_DISPLAY, 0, 0));
		issue(make_op(ACT_CLEAR, 0, 0));
		issue(make_op(ACT_DISPLAY, 0, 0));

		// fill to full under a long output hold-off, then the full-array cases
		hold_off = 1'b1;
		while (mirror.fill < DEPTH_DEF) issue(make_op(ACT_APPEND, pick_value(), 0));
		issue(make_op(ACT_APPEND, 5, 0));
		issue(make_op(ACT_INSERT, 9, 0));
		issue(make_op(ACT_INSERT, 9, 1));
		issue(make_op(ACT_SEARCH, 0, 0));
		issue(make_op(ACT_DISPLAY, 0, 0));
		issue(make_op(ACT_DELETE, 0, 33));
		issue(make_op(ACT_DELETE, 0, 32));
		issue(make_op(ACT_INSERT, 4, 33));
		issue(make_op(ACT_INSERT, 4, 32));
		issue(make_op(ACT_DELETE, 0, 1));
		issue(make_op(ACT_SEARCH, 1, 0));

		for (int n = 0; n < 70; n++) begin
			calm = (n >= 55);
			random_op();
		end
		req_valid <= 1'b0;

		while (mirror.pending_words.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mirror.mismatches == 0 && mirror.pending_words.size() == 0) begin
			$display("** array_insert_delete_search_unit: PASSED **");
		end else begin
			$display("** array_insert_delete_search_unit: FAILED **");
		end
		$finish;
	end

endmodule
